/* src/i2cbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bus monitor package
// Shared constants, event codes and the result record of the bus monitor.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  // Line positions inside the raw sample byte.
  localparam int SDA_BIT = 4;
  localparam int SCL_BIT = 5;

  // Data bits in one byte before the acknowledge clock.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Saturation limit of the byte index.
  localparam logic [7:0] BYTE_COUNT_MAX = 8'hFF;

  // Reported gap field.
  localparam int OUT_GAP_WIDTH = 24;
  localparam logic [OUT_GAP_WIDTH-1:0] OUT_GAP_MAX = {OUT_GAP_WIDTH{1'b1}};

  // Default width of the internal gap counter.
  localparam int GAP_WIDTH_DEFAULT = 24;

  // Event codes carried by each result item.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2,
    EV_BYTE  = 2'd3
  } event_kind_t;

  // One result item.
  typedef struct packed {
    event_kind_t              event_kind;
    logic [7:0]               byte_value;
    logic [7:0]               byte_position;
    logic [3:0]               bits_pending;
    logic                     is_address;
    logic [6:0]               device_address;
    logic                     read_not_write;
    logic                     acked;
    logic [OUT_GAP_WIDTH-1:0] gap_ticks;
  } result_t;

endpackage

/* src/i2cbm_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bus monitor step logic
// Holds the bus tracking state and decodes one registered line sample into
// one result item; the state advances only when the item moves on.
// ----------------------------------------------------------------------------
module i2cbm_step #(
  parameter int GAP_WIDTH = i2cbm_pkg::GAP_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          sample,
  output i2cbm_pkg::result_t  result
);
  import i2cbm_pkg::*;

  localparam int CMP_WIDTH = (GAP_WIDTH > OUT_GAP_WIDTH) ? GAP_WIDTH : OUT_GAP_WIDTH;
  localparam logic [GAP_WIDTH-1:0] GAP_MAX = {GAP_WIDTH{1'b1}};

  // Tracking state.
  logic                 have_previous, have_previous_next;
  logic                 previous_sda, previous_sda_next;
  logic                 previous_scl, previous_scl_next;
  logic [3:0]           bit_count, bit_count_next;
  logic [7:0]           shift_data, shift_data_next;
  logic [7:0]           byte_count, byte_count_next;
  logic [GAP_WIDTH-1:0] tick_gap, tick_gap_next;

  logic                 sda;
  logic                 scl;
  logic [GAP_WIDTH-1:0] gap_inc;
  logic [CMP_WIDTH-1:0] gap_ext;
  logic [OUT_GAP_WIDTH-1:0] gap_out;

  assign sda = sample[SDA_BIT];
  assign scl = sample[SCL_BIT];

  // Gap counter saturates at its own limit, then at the reported limit.
  assign gap_inc = (tick_gap != GAP_MAX) ? GAP_WIDTH'(tick_gap + 1'b1) : tick_gap;
  assign gap_ext = CMP_WIDTH'(gap_inc);
  assign gap_out = (gap_ext > CMP_WIDTH'(OUT_GAP_MAX)) ? OUT_GAP_MAX
                                                       : gap_ext[OUT_GAP_WIDTH-1:0];

  // Edge decode and next state.
  always_comb begin
    result             = '0;
    result.event_kind  = EV_NONE;
    have_previous_next = 1'b1;
    previous_sda_next  = sda;
    previous_scl_next  = scl;
    bit_count_next     = bit_count;
    shift_data_next    = shift_data;
    byte_count_next    = byte_count;
    tick_gap_next      = gap_inc;

    if (have_previous) begin
      if (previous_scl && scl) begin
        if (previous_sda && !sda) begin
          // Start condition: a new transfer begins.
          bit_count_next    = '0;
          byte_count_next   = '0;
          shift_data_next   = '0;
          result.event_kind = EV_START;
        end else if (!previous_sda && sda) begin
          // Stop condition: report progress, clear nothing.
          result.event_kind    = EV_STOP;
          result.byte_position = byte_count;
          result.bits_pending  = bit_count;
        end
      end else if (!previous_scl && scl) begin
        if (bit_count >= BITS_PER_BYTE) begin
          // Acknowledge clock: the byte is complete.
          result.event_kind    = EV_BYTE;
          result.byte_value    = shift_data;
          result.byte_position = byte_count;
          if (byte_count == '0) begin
            result.is_address     = 1'b1;
            result.device_address = shift_data[7:1];
            result.read_not_write = shift_data[0];
          end
          result.acked      = !sda;
          result.gap_ticks  = gap_out;
          bit_count_next    = '0;
          shift_data_next   = '0;
          if (byte_count != BYTE_COUNT_MAX) begin
            byte_count_next = 8'(byte_count + 1'b1);
          end
          tick_gap_next     = '0;
        end else begin
          // Data clock: shift in one bit, MSB first.
          shift_data_next = {shift_data[6:0], sda};
          bit_count_next  = 4'(bit_count + 1'b1);
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      previous_sda  <= 1'b0;
      previous_scl  <= 1'b0;
      bit_count     <= '0;
      shift_data    <= '0;
      byte_count    <= '0;
      tick_gap      <= '0;
    end else if (advance) begin
      have_previous <= have_previous_next;
      previous_sda  <= previous_sda_next;
      previous_scl  <= previous_scl_next;
      bit_count     <= bit_count_next;
      shift_data    <= shift_data_next;
      byte_count    <= byte_count_next;
      tick_gap      <= tick_gap_next;
    end
  end

endmodule

/* src/i2c_bus_monitor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bus monitor core
// Passive bus sniffer: one raw line sample in, one event item out per sample.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake                    Payload
//   sample    in          sample_valid / sample_stall  line_sample
//   result    out         result_valid / result_stall  event_kind .. gap_ticks
//
// One item is accepted every cycle while the result side keeps up.
// An item passes a sample register, then the decode into the result
// register. The result register stall reaches the sample side in the same
// cycle, so the block keeps one item in each register while stalled.
// Reset clears both valid flags and all bus tracking state.
// ----------------------------------------------------------------------------
module i2c_bus_monitor_core #(
  parameter int GAP_WIDTH = i2cbm_pkg::GAP_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic [7:0]                            line_sample,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output i2cbm_pkg::event_kind_t                event_kind,
  output logic [7:0]                            byte_value,
  output logic [7:0]                            byte_position,
  output logic [3:0]                            bits_pending,
  output logic                                  is_address,
  output logic [6:0]                            device_address,
  output logic                                  read_not_write,
  output logic                                  acked,
  output logic [i2cbm_pkg::OUT_GAP_WIDTH-1:0]   gap_ticks
);
  import i2cbm_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_sample;
  logic       out_ready;
  logic       hold_ready;
  logic       advance;
  result_t    step_result;
  result_t    result_q;

  // Handshake chain between the two registers.
  assign out_ready    = !result_valid || !result_stall;
  assign hold_ready   = !hold_valid || out_ready;
  assign advance      = hold_valid && out_ready;
  assign sample_stall = !hold_ready;

  // Sample register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hold_ready) begin
      hold_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_ready && sample_valid) begin
      hold_sample <= line_sample;
    end
  end

  // Decode and bus state.
  i2cbm_step #(
    .GAP_WIDTH (GAP_WIDTH)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (hold_sample),
    .result  (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= step_result;
    end
  end

  assign event_kind     = result_q.event_kind;
  assign byte_value     = result_q.byte_value;
  assign byte_position  = result_q.byte_position;
  assign bits_pending   = result_q.bits_pending;
  assign is_address     = result_q.is_address;
  assign device_address = result_q.device_address;
  assign read_not_write = result_q.read_not_write;
  assign acked          = result_q.acked;
  assign gap_ticks      = result_q.gap_ticks;

endmodule

/* src/i2cbm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bus monitor checker
// Port-level assertions on the bus monitor, attached by a bind statement.
// ----------------------------------------------------------------------------
module i2cbm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_stall,
  input logic                                result_valid,
  input logic                                result_stall,
  input i2cbm_pkg::event_kind_t              event_kind,
  input logic [7:0]                          byte_value,
  input logic [7:0]                          byte_position,
  input logic [3:0]                          bits_pending,
  input logic                                is_address,
  input logic [6:0]                          device_address,
  input logic                                read_not_write,
  input logic                                acked,
  input logic [i2cbm_pkg::OUT_GAP_WIDTH-1:0] gap_ticks
);
  import i2cbm_pkg::*;

  // A stalled result item holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(event_kind)
      && $stable(byte_value) && $stable(gap_ticks) && $stable(byte_position))
    else $error("stalled result item changed");

  // Every accepted sample yields a result item after the sample and result registers.
  a_sample_to_result: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> ##1 result_valid)
    else $error("accepted item produced no result");

  // Byte-only fields stay zero on other events.
  a_non_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_kind != EV_BYTE |->
      byte_value == 8'd0 && gap_ticks == '0 && acked == 1'b0 && is_address == 1'b0)
    else $error("byte fields set on a non-byte event");

  // Address decode matches the byte and only occurs on the first byte.
  a_address_decode: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_address |->
      event_kind == EV_BYTE && byte_position == 8'd0
      && device_address == byte_value[7:1] && read_not_write == byte_value[0])
    else $error("address decode inconsistent");

  // Bits pending is reported only at a stop and never exceeds one byte.
  a_bits_pending: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (event_kind == EV_STOP && bits_pending <= BITS_PER_BYTE)
      || bits_pending == 4'd0)
    else $error("bits pending out of place");

endmodule

bind i2c_bus_monitor_core i2cbm_checker u_i2cbm_checker (.*);
